>>> hdl/ps2mct_pkg.sv
// Package for the PS/2 mouse packet decoder and cursor tracker.
// Holds the header bit positions, packet phase codes, limits and beat layout.
// No dependencies; imported by ps2_mouse_packet_cursor_tracker_top.
package ps2mct_pkg;

	// Header byte bit positions
	localparam int unsigned BIT_LEFT   = 0;
	localparam int unsigned BIT_RIGHT  = 1;
	localparam int unsigned BIT_MIDDLE = 2;
	localparam int unsigned BIT_SYNC   = 3;
	localparam int unsigned BIT_X_SIGN = 4;
	localparam int unsigned BIT_Y_SIGN = 5;
	localparam int unsigned BIT_X_OVF  = 6;
	localparam int unsigned BIT_Y_OVF  = 7;

	// Packet phase codes
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_X      = 2'd1;
	localparam logic [1:0] PH_Y      = 2'd2;

	// Configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Widths
	localparam int unsigned SIZE_W  = 14;
	localparam int unsigned POS_W   = 13;
	localparam int unsigned DELTA_W = 11;
	localparam int unsigned SUM_W   = 15;
	localparam int unsigned OUT_W   = 32;

	// Arithmetic constants
	localparam logic signed [DELTA_W-1:0] SIGN_SPAN = 11'sd256;
	localparam logic signed [DELTA_W-1:0] OVF_STEP  = 11'sd255;
	localparam logic signed [SUM_W-1:0]   X_MARGIN  = 15'sd8;
	localparam logic signed [SUM_W-1:0]   Y_MARGIN  = 15'sd16;
	localparam logic [POS_W-1:0]          X_LIMIT_MAX = 13'd8184;
	localparam logic [POS_W-1:0]          Y_LIMIT_MAX = 13'd8176;

	// Reset values
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd480;
	localparam logic [POS_W-1:0]  POS_RESET    = 13'd10;

	// Result beat, highest bit first
	typedef struct packed {
		logic [OUT_W-POS_W-POS_W-4:0] pad;
		logic                         middle_pressed;
		logic                         right_pressed;
		logic                         left_pressed;
		logic [POS_W-1:0]             cursor_y;
		logic [POS_W-1:0]             cursor_x;
	} result_t;

endpackage

>>> hdl/ps2_mouse_packet_cursor_tracker_top.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
// Depends on ps2mct_pkg for constants and the result beat layout.
//
// Usage:
//   s_axis carries one byte from the mouse data port per beat. A packet starts
//   on a byte with bit 3 set, followed by the X and Y delta bytes; other bytes
//   arriving while waiting for a header are dropped.
//   m_axis carries one beat per completed packet: the clamped cursor position
//   and the three button bits of the header.
//   cfg_we/cfg_index/cfg_data write screen_width (index 0) or screen_height
//   (index 1); write only while idle.
//   Throughput: one byte per cycle while the output register can take a
//   result. A byte is held in an input register; the delta decode, add and
//   clamp then run in a single pass into the output register.
//   When the receiver stalls, the output register holds its beat; the input
//   register keeps taking header and X bytes, and stalls on a Y byte until the
//   output register frees.
//   Reset: phase waits for a header, cursor at (10, 10), 640 x 480 screen,
//   no beat pending.
module ps2_mouse_packet_cursor_tracker_top
	import ps2mct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,   // [12:0] cursor_x, [25:13] cursor_y,
	                                          // [26] left_pressed, [27] right_pressed,
	                                          // [28] middle_pressed, [31:29] zero
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] width_q, height_q;
	logic [1:0]        phase_q;
	logic [7:0]        header_q, xbyte_q;
	logic [POS_W-1:0]  pos_x_q, pos_y_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	result_t           result_q;
	logic              out_valid_q;

	logic              is_y_byte, out_free, advance_s1, load_out;
	logic signed [DELTA_W-1:0] dx, dy;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic [POS_W-1:0]  lim_x, lim_y, new_x, new_y;

	// Delta as 9-bit two's complement plus optional overflow step
	function automatic logic signed [DELTA_W-1:0] decode_delta(
		input logic [7:0] raw, input logic neg, input logic ovf);
		logic signed [DELTA_W-1:0] d;
		d = $signed({{(DELTA_W-8){1'b0}}, raw});
		if (neg) d = d - SIGN_SPAN;
		if (ovf) d = neg ? d - OVF_STEP : d + OVF_STEP;
		return d;
	endfunction

	// Screen size minus margin, saturated to 0..cap
	function automatic logic [POS_W-1:0] upper_limit(
		input logic [SIZE_W-1:0] size, input logic signed [SUM_W-1:0] margin,
		input logic [POS_W-1:0] cap);
		logic signed [SUM_W-1:0] lim;
		lim = $signed({1'b0, size}) - margin;
		if (lim < 0) return '0;
		if (lim > $signed({{(SUM_W-POS_W){1'b0}}, cap})) return cap;
		return lim[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] clamp(
		input logic signed [SUM_W-1:0] v, input logic [POS_W-1:0] hi);
		if (v < 0) return '0;
		if (v > $signed({{(SUM_W-POS_W){1'b0}}, hi})) return hi;
		return v[POS_W-1:0];
	endfunction

	// Handshake: a Y byte needs a free output register
	assign is_y_byte     = (phase_q == PH_Y);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance_s1    = valid_s1 && (!is_y_byte || out_free);
	assign load_out      = advance_s1 && is_y_byte;
	assign s_axis_tready = !valid_s1 || advance_s1;

	// Decode, move and clamp
	always_comb begin
		dx    = decode_delta(xbyte_q, header_q[BIT_X_SIGN], header_q[BIT_X_OVF]);
		dy    = decode_delta(byte_s1, header_q[BIT_Y_SIGN], header_q[BIT_Y_OVF]);
		sum_x = $signed({{(SUM_W-POS_W){1'b0}}, pos_x_q})
			+ {{(SUM_W-DELTA_W){dx[DELTA_W-1]}}, dx};
		sum_y = $signed({{(SUM_W-POS_W){1'b0}}, pos_y_q})
			- {{(SUM_W-DELTA_W){dy[DELTA_W-1]}}, dy};
		lim_x = upper_limit(width_q, X_MARGIN, X_LIMIT_MAX);
		lim_y = upper_limit(height_q, Y_MARGIN, Y_LIMIT_MAX);
		new_x = clamp(sum_x, lim_x);
		new_y = clamp(sum_y, lim_y);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Packet phase and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_x_q <= POS_RESET;
			pos_y_q <= POS_RESET;
		end else if (advance_s1) begin
			unique case (phase_q)
				PH_X: phase_q <= PH_Y;
				PH_Y: begin
					phase_q <= PH_HEADER;
					pos_x_q <= new_x;
					pos_y_q <= new_y;
				end
				default: phase_q <= byte_s1[BIT_SYNC] ? PH_X : PH_HEADER;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			if (phase_q == PH_X) begin
				xbyte_q <= byte_s1;
			end else if (!is_y_byte && byte_s1[BIT_SYNC]) begin
				header_q <= byte_s1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.pad            <= '0;
			result_q.cursor_x       <= new_x;
			result_q.cursor_y       <= new_y;
			result_q.left_pressed   <= header_q[BIT_LEFT];
			result_q.right_pressed  <= header_q[BIT_RIGHT];
			result_q.middle_pressed <= header_q[BIT_MIDDLE];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	// Checks
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) || (phase_q == PH_X) || (phase_q == PH_Y))
		else $error("packet phase reached an unused code");

	a_load_only_on_y: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (phase_q == PH_Y) && out_free)
		else $error("result loaded outside the Y byte or over a pending beat");

	a_x_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_x_q <= X_LIMIT_MAX && pos_y_q <= Y_LIMIT_MAX)
		else $error("cursor position beyond its cap");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

endmodule

>>> tb/tb_ps2_mouse_packet_cursor_tracker_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ps2_mouse_packet_cursor_tracker_top: streams mouse bytes,
// tracks packet phase and cursor position alongside the block and checks each result beat.
// Depends on ps2mct_pkg and the top level only.
module tb_ps2_mouse_packet_cursor_tracker_top;
	import ps2mct_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;    // [7:0] data_byte
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;         // [12:0] cursor_x, [25:13] cursor_y,
	                                         // [26] left, [27] right, [28] middle
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_WIDTH;
	logic [SIZE_W-1:0] cfg_data = '0;

	ps2_mouse_packet_cursor_tracker_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the tracker state
	logic [1:0]        pkt_phase = PH_HEADER;
	logic [7:0]        hdr_byte = '0;
	logic [7:0]        dx_byte = '0;
	int                cur_x = int'(POS_RESET);
	int                cur_y = int'(POS_RESET);
	logic [SIZE_W-1:0] scr_width = WIDTH_RESET;
	logic [SIZE_W-1:0] scr_height = HEIGHT_RESET;

	// Traffic bookkeeping
	logic [7:0] mouse_bytes[$];
	result_t    cursor_updates[$];
	int         bytes_queued = 0;
	int         bytes_taken = 0;
	int         mismatch_count = 0;
	bit         byte_taken = 1'b0;
	bit         calm = 1'b0;
	bit         hold_req = 1'b0;
	int         send_gap = 0;
	int         ready_gap = 0;
	int         hold_left = 0;

	function automatic int delta_value(input logic [7:0] raw, input logic neg, input logic ovf);
		int d;
		d = int'(raw);
		if (neg)
			d -= int'(SIGN_SPAN);
		if (ovf)
			d += neg ? -int'(OVF_STEP) : int'(OVF_STEP);
		return d;
	endfunction

	function automatic int bound(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the packet phase by one byte; a Y byte moves the cursor and queues a result
	task automatic track_byte(input logic [7:0] b);
		int      dx;
		int      dy;
		int      x_top;
		int      y_top;
		result_t r;
		case (pkt_phase)
			PH_X: begin
				dx_byte = b;
				pkt_phase = PH_Y;
			end
			PH_Y: begin
				pkt_phase = PH_HEADER;
				dx = delta_value(dx_byte, hdr_byte[BIT_X_SIGN], hdr_byte[BIT_X_OVF]);
				dy = delta_value(b, hdr_byte[BIT_Y_SIGN], hdr_byte[BIT_Y_OVF]);
				x_top = bound(int'(scr_width) - int'(X_MARGIN), 0, int'(X_LIMIT_MAX));
				y_top = bound(int'(scr_height) - int'(Y_MARGIN), 0, int'(Y_LIMIT_MAX));
				cur_x = bound(cur_x + dx, 0, x_top);
				cur_y = bound(cur_y - dy, 0, y_top);
				r = '0;
				r.cursor_x = POS_W'(cur_x);
				r.cursor_y = POS_W'(cur_y);
				r.left_pressed = hdr_byte[BIT_LEFT];
				r.right_pressed = hdr_byte[BIT_RIGHT];
				r.middle_pressed = hdr_byte[BIT_MIDDLE];
				cursor_updates.push_back(r);
			end
			default: begin
				// waiting for a header: bytes without the sync bit are dropped
				pkt_phase = PH_HEADER;
				if (b[BIT_SYNC]) begin
					hdr_byte = b;
					pkt_phase = PH_X;
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	function automatic void queue_byte(input logic [7:0] b);
		mouse_bytes.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void queue_packet(input logic [7:0] h, input logic [7:0] x,
	                                     input logic [7:0] y);
		queue_byte(h);
		queue_byte(x);
		queue_byte(y);
	endfunction

	// Mostly well-formed packets with random content, the rest stray bytes
	task automatic queue_random_traffic(input int n);
		logic [7:0] h;
		while (n > 0) begin
			if ($urandom_range(0, 9) < 8) begin
				h = 8'($urandom_range(0, 255));
				h[BIT_SYNC] = 1'b1;
				queue_packet(h, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				n -= 3;
			end else begin
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom_range(0, 255)));
				n -= 2;
			end
		end
	endtask

	// All bytes accepted, all results back, then let the pipeline settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (bytes_taken != bytes_queued || cursor_updates.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		scr_width = w;
		scr_height = h;
	endtask

	// Byte driver: a new beat only once the current one has been taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			byte_taken = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (mouse_bytes.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 3);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tdata <= mouse_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// Input beat accepted: update the mirror
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			track_byte(s_axis_tdata);
			byte_taken = 1'b1;
			bytes_taken++;
		end
	end

	// Receiver readiness: random short stalls, plus one long hold on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 299;
				m_axis_tready <= 1'b0;
			end else if (ready_gap != 0) begin
				ready_gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				ready_gap = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result beat accepted: compare with the oldest expected cursor update
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata);
			if (cursor_updates.size() == 0) begin
				$error("unexpected result beat: %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = cursor_updates.pop_front();
				check_field("cursor_x", want.cursor_x, got.cursor_x);
				check_field("cursor_y", want.cursor_y, got.cursor_y);
				check_field("left_pressed", want.left_pressed, got.left_pressed);
				check_field("right_pressed", want.right_pressed, got.right_pressed);
				check_field("middle_pressed", want.middle_pressed, got.middle_pressed);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	// Stimulus sequence
	initial begin
		logic [SIZE_W-1:0] widths [10];
		logic [SIZE_W-1:0] heights [10];
		widths = '{14'd640, 14'd8, 14'd0, 14'd7, 14'd16383, 14'd8192, 14'd8191, 14'd9,
		           14'd0, 14'd0};
		heights = '{14'd480, 14'd16, 14'd0, 14'd15, 14'd16383, 14'd8192, 14'd8191, 14'd17,
		            14'd0, 14'd0};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: stray bytes, buttons, sign and overflow extremes, at reset screen size
		queue_byte(8'h00);
		queue_byte(8'hF7);
		queue_packet(8'h0F, 8'h00, 8'h00);
		queue_packet(8'h48, 8'hFF, 8'h00);
		queue_packet(8'hF8, 8'h00, 8'h00);
		queue_packet(8'h89, 8'h08, 8'hFF);
		queue_packet(8'h0A, 8'h7F, 8'h80);
		queue_packet(8'h3C, 8'h01, 8'hFF);
		wait_drained();

		// Random phases over a range of screen sizes; the last runs without idling
		for (int i = 0; i < 10; i++) begin
			if (i >= 8) begin
				widths[i] = SIZE_W'($urandom_range(0, 16383));
				heights[i] = SIZE_W'($urandom_range(0, 16383));
			end
			write_screen(widths[i], heights[i]);
			if (i == 9)
				calm = 1'b1;
			queue_random_traffic(170);
			if (i == 0)
				hold_req = 1'b1;
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ps2mct_pkg.sv
hdl/ps2_mouse_packet_cursor_tracker_top.sv
tb/tb_ps2_mouse_packet_cursor_tracker_top.sv
